[src/assert_macros.svh]
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define DPL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be true outside reset
`define DPL_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[src/dpl_pkg.sv]
// types, constants and helpers of the dataflash ping-pong log writer
package dpl_pkg;

  localparam int unsigned PageBits   = 13;
  localparam int unsigned OffsetBits = 11;
  localparam int unsigned ShiftBits  = 4;
  localparam int unsigned AddrBits   = 24;
  localparam int unsigned CfgIdxBits = 2;

  // flash opcodes
  localparam logic [7:0] OP_WR_BUF_ONE  = 8'h84;
  localparam logic [7:0] OP_WR_BUF_ZERO = 8'h87;
  localparam logic [7:0] OP_COMMIT_ONE  = 8'h88;
  localparam logic [7:0] OP_COMMIT_ZERO = 8'h89;

  // configuration register indexes
  localparam logic [CfgIdxBits-1:0] CFG_BUFFER_SIZE    = 2'd0;
  localparam logic [CfgIdxBits-1:0] CFG_BYTE_ADDR_BITS = 2'd1;

  // reset values of the configuration registers
  localparam logic [OffsetBits-1:0] BufferSizeReset = 11'd528;
  localparam logic [ShiftBits-1:0]  AddrBitsReset   = 4'd10;

  // output slots: commit frame 0..3, header frame 4..7, data byte 8
  localparam int unsigned SlotBits = 4;
  localparam logic [SlotBits-1:0] SLOT_COMMIT_FIRST = 4'd0;
  localparam logic [SlotBits-1:0] SLOT_COMMIT_LAST  = 4'd3;
  localparam logic [SlotBits-1:0] SLOT_HDR_FIRST    = 4'd4;
  localparam logic [SlotBits-1:0] SLOT_HDR_LAST     = 4'd7;
  localparam logic [SlotBits-1:0] SLOT_DATA         = 4'd8;

  typedef enum logic [1:0] {
    MODE_DATA    = 2'd0,
    MODE_SYNC    = 2'd1,
    MODE_RESTART = 2'd2,
    MODE_IGNORE  = 2'd3
  } mode_e;

  typedef struct packed {
    logic [1:0]            mode;
    logic [7:0]            data_byte;
    logic [OffsetBits-1:0] record_length;
    logic                  first_in_record;
    logic                  last_in_record;
  } in_item_t;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic       end_of_frame;
    logic       last_result;
  } out_item_t;

  // everything the emitter needs to send the results of one transaction
  typedef struct packed {
    logic                has_commit;
    logic [7:0]          commit_op;
    logic [AddrBits-1:0] commit_addr;
    logic                has_header;
    logic [7:0]          header_op;
    logic [AddrBits-1:0] header_addr;
    logic                has_data;
    logic [7:0]          data_byte;
    logic                data_eof;
  } plan_t;

endpackage

[src/dpl_plan.sv]
// state, configuration and per-transaction frame planning
module dpl_plan (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  dpl_pkg::in_item_t                   item_i,
  input  logic                                cfg_we_i,
  input  logic [dpl_pkg::CfgIdxBits-1:0]      cfg_index_i,
  input  logic [dpl_pkg::OffsetBits-1:0]      cfg_data_i,
  output logic                                plan_load_o,
  output dpl_pkg::plan_t                      plan_o
);
  import dpl_pkg::*;
  `include "assert_macros.svh"

  logic [OffsetBits-1:0] buffer_size_q;
  logic [ShiftBits-1:0]  addr_bits_q;
  logic                  active_buffer_q, active_buffer_d;
  logic [OffsetBits-1:0] fill_offset_q, fill_offset_d;
  logic [PageBits-1:0]   page_q, page_d;

  logic [OffsetBits:0]          offset_sum;
  logic [PageBits+15-1:0]       page_shifted;
  logic                         do_commit;
  logic                         buf_after;
  logic [OffsetBits-1:0]        off_after;
  logic [PageBits-1:0]          page_after;
  logic                         is_restart;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buffer_size_q <= BufferSizeReset;
      addr_bits_q   <= AddrBitsReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_BUFFER_SIZE) begin
        buffer_size_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_BYTE_ADDR_BITS) begin
        addr_bits_q <= cfg_data_i[ShiftBits-1:0];
      end
    end
  end

  // commit decision and address
  always_comb begin
    offset_sum   = {1'b0, fill_offset_q} + {1'b0, item_i.record_length};
    page_shifted = {15'd0, page_q} << addr_bits_q;
    do_commit    = 1'b0;
    is_restart   = 1'b0;
    plan_load_o  = 1'b0;
    unique case (mode_e'(item_i.mode))
      MODE_DATA: begin
        do_commit   = item_i.first_in_record && (offset_sum >= {1'b0, buffer_size_q});
        plan_load_o = accept_i;
      end
      MODE_SYNC: begin
        do_commit   = (fill_offset_q != '0);
        plan_load_o = accept_i && do_commit;
      end
      MODE_RESTART: is_restart = 1'b1;
      MODE_IGNORE:  ;
      default:      ;
    endcase
  end

  // state as seen after an optional commit
  assign buf_after  = do_commit ? ~active_buffer_q : active_buffer_q;
  assign off_after  = do_commit ? '0 : fill_offset_q;
  assign page_after = do_commit ? page_q + 1'b1 : page_q;

  // frame plan for the emitter
  always_comb begin
    plan_o.has_commit  = do_commit;
    plan_o.commit_op   = active_buffer_q ? OP_COMMIT_ONE : OP_COMMIT_ZERO;
    plan_o.commit_addr = page_shifted[AddrBits-1:0];
    plan_o.has_header  = (mode_e'(item_i.mode) == MODE_DATA) && item_i.first_in_record;
    plan_o.header_op   = buf_after ? OP_WR_BUF_ONE : OP_WR_BUF_ZERO;
    plan_o.header_addr = {{(AddrBits-OffsetBits){1'b0}}, off_after};
    plan_o.has_data    = (mode_e'(item_i.mode) == MODE_DATA);
    plan_o.data_byte   = item_i.data_byte;
    plan_o.data_eof    = item_i.last_in_record;
  end

  // next state
  always_comb begin
    active_buffer_d = active_buffer_q;
    fill_offset_d   = fill_offset_q;
    page_d          = page_q;
    if (accept_i) begin
      if (is_restart) begin
        active_buffer_d = 1'b0;
        fill_offset_d   = '0;
        page_d          = '0;
      end else begin
        active_buffer_d = buf_after;
        page_d          = page_after;
        fill_offset_d   = plan_o.has_header ? off_after + item_i.record_length : off_after;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_buffer_q <= 1'b0;
      fill_offset_q   <= '0;
      page_q          <= '0;
    end else begin
      active_buffer_q <= active_buffer_d;
      fill_offset_q   <= fill_offset_d;
      page_q          <= page_d;
    end
  end

  // a restart leaves the writer at buffer zero, offset zero, page zero
  `DPL_ASSERT(a_restart_clears, clk_i, rst_ni,
    accept_i && is_restart |=> fill_offset_q == '0 && page_q == '0 && !active_buffer_q,
    "restart did not clear state")

endmodule

[src/dpl_emit.sv]
// holds one planned transaction and sends its bytes through the output register
module dpl_emit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               plan_load_i,
  input  dpl_pkg::plan_t     plan_i,
  output logic               busy_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dpl_pkg::out_item_t out_data_o
);
  import dpl_pkg::*;
  `include "assert_macros.svh"

  logic                plan_valid_q, plan_valid_d;
  plan_t               plan_q;
  logic [SlotBits-1:0] slot_q, slot_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_q;
  logic                out_ready;
  logic                slot_last;
  logic [SlotBits-1:0] slot_next;
  logic [SlotBits-1:0] slot_start;
  logic [AddrBits-1:0] frame_addr;
  logic [7:0]          frame_op;
  out_item_t           slot_item;

  assign out_ready = !out_valid_q || !out_stall_i;

  // slot sequencing
  always_comb begin
    slot_last  = (slot_q == SLOT_DATA) || ((slot_q == SLOT_COMMIT_LAST) && !plan_q.has_data);
    slot_next  = ((slot_q == SLOT_COMMIT_LAST) && !plan_q.has_header) ? SLOT_DATA
                                                                        : slot_q + 1'b1;
    slot_start = plan_i.has_commit ? SLOT_COMMIT_FIRST :
                 plan_i.has_header ? SLOT_HDR_FIRST : SLOT_DATA;
  end

  // byte of the current slot
  always_comb begin
    frame_addr = (slot_q < SLOT_HDR_FIRST) ? plan_q.commit_addr : plan_q.header_addr;
    frame_op   = (slot_q < SLOT_HDR_FIRST) ? plan_q.commit_op : plan_q.header_op;
    slot_item.last_result  = slot_last;
    slot_item.end_of_frame = 1'b0;
    if (slot_q == SLOT_DATA) begin
      slot_item.spi_byte     = plan_q.data_byte;
      slot_item.end_of_frame = plan_q.data_eof;
    end else begin
      unique case (slot_q[1:0])
        2'd0:    slot_item.spi_byte = frame_op;
        2'd1:    slot_item.spi_byte = frame_addr[23:16];
        2'd2:    slot_item.spi_byte = frame_addr[15:8];
        2'd3:    slot_item.spi_byte = frame_addr[7:0];
        default: slot_item.spi_byte = frame_op;
      endcase
      slot_item.end_of_frame = (slot_q == SLOT_COMMIT_LAST);
    end
  end

  // a new transaction is taken once the last byte of the held one moves out
  assign busy_o = plan_valid_q && !(out_ready && slot_last);

  always_comb begin
    plan_valid_d = plan_valid_q;
    slot_d       = slot_q;
    out_valid_d  = out_valid_q;
    if (out_ready) begin
      out_valid_d = plan_valid_q;
      if (plan_valid_q) begin
        if (slot_last) begin
          plan_valid_d = 1'b0;
        end else begin
          slot_d = slot_next;
        end
      end
    end
    if (plan_load_i) begin
      plan_valid_d = 1'b1;
      slot_d       = slot_start;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plan_valid_q <= 1'b0;
      slot_q       <= SLOT_COMMIT_FIRST;
      out_valid_q  <= 1'b0;
    end else begin
      plan_valid_q <= plan_valid_d;
      slot_q       <= slot_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (plan_load_i) begin
      plan_q <= plan_i;
    end
    if (out_ready && plan_valid_q) begin
      out_q <= slot_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `DPL_ASSERT(a_slot_range, clk_i, rst_ni, plan_valid_q |-> slot_q <= SLOT_DATA,
    "slot index out of range")
  `DPL_ASSERT(a_header_has_data, clk_i, rst_ni,
    plan_valid_q && plan_q.has_header |-> plan_q.has_data, "header without data byte")
  `DPL_NEVER(a_empty_plan, clk_i, rst_ni,
    plan_valid_q && !plan_q.has_commit && !plan_q.has_data, "held plan has no results")
  `DPL_NEVER(a_load_while_busy, clk_i, rst_ni, plan_load_i && busy_o,
    "plan loaded while previous one still pending")

endmodule

[src/dataflash_pingpong_log_writer_top.sv]
// top level of the dataflash ping-pong log writer
// Turns log records, one byte per transaction, into SPI command bytes for a
// two-buffer serial flash. A data byte that continues a record gives one
// output byte, and such transactions are taken every cycle while the output
// is not stalled. The first byte of a record gives a four-byte
// write-to-buffer header before the data byte, and four more commit bytes
// first when the record would reach the end of the active buffer, so one
// input transaction gives 1, 5 or 9 output bytes; a sync with data gives 4,
// and restart, an empty sync and mode three give nothing. The single output
// register sends one byte per cycle while the receiver does not stall it.
// The next input transaction is taken in the cycle the last byte of the
// current one enters the output register. Configuration writes are always
// ready and belong only to idle periods.
module dataflash_pingpong_log_writer_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  dpl_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output dpl_pkg::out_item_t             out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dpl_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [dpl_pkg::OffsetBits-1:0] cfg_data_i
);
  import dpl_pkg::*;

  logic  busy;
  logic  accept;
  logic  plan_load;
  plan_t plan;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy;
  assign accept      = in_valid_i && !busy;

  // frame planning and writer state
  dpl_plan u_plan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_data_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .plan_load_o (plan_load),
    .plan_o      (plan)
  );

  // byte sequencing to the output register
  dpl_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .plan_load_i (plan_load),
    .plan_i      (plan),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[verif/dataflash_pingpong_log_writer_top_tb.sv]
// self-checking testbench of the dataflash ping-pong log writer top level
`timescale 1ns / 100ps

module dataflash_pingpong_log_writer_top_tb;
  import dpl_pkg::*;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;

  // block ports
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CfgIdxBits-1:0] cfg_index_i = '0;
  logic [OffsetBits-1:0] cfg_data_i = '0;

  // stimulus and expectations
  in_item_t  log_byte_q[$];
  out_item_t spi_expect_q[$];
  int unsigned fail_count = 0;

  // handshake bookkeeping and idling control
  logic        in_taken = 1'b0;
  int unsigned in_gap_left = 0;
  int unsigned stall_left = 0;
  logic        idle_en = 1'b1;
  logic        hold_go = 1'b0;
  logic        hold_off = 1'b0;

  // writer state as predicted, plus the register copies
  logic                  pred_buf;
  logic [OffsetBits-1:0] pred_off;
  logic [PageBits-1:0]   pred_page;
  logic [OffsetBits-1:0] cfg_size;
  logic [ShiftBits-1:0]  cfg_shift;

  dataflash_pingpong_log_writer_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #10 clk = ~clk;

  // mostly no gap, some short ones, a few long ones
  function automatic int unsigned random_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_en || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_item_t make_item(mode_e m, logic [7:0] b, logic [OffsetBits-1:0] len,
                                         logic first, logic last);
    in_item_t it;
    it.mode            = m;
    it.data_byte       = b;
    it.record_length   = len;
    it.first_in_record = first;
    it.last_in_record  = last;
    return it;
  endfunction

  function automatic void expect_byte(logic [7:0] b, logic eof);
    out_item_t o;
    o.spi_byte     = b;
    o.end_of_frame = eof;
    o.last_result  = 1'b0;
    spi_expect_q.push_back(o);
  endfunction

  // opcode then a 24-bit address, msb first
  function automatic void expect_frame(logic [7:0] op, logic [AddrBits-1:0] addr, logic eof);
    expect_byte(op, 1'b0);
    expect_byte(addr[23:16], 1'b0);
    expect_byte(addr[15:8], 1'b0);
    expect_byte(addr[7:0], eof);
  endfunction

  // buffer-to-page program, then swap buffers and move to the next page
  function automatic void expect_page_commit();
    logic [63:0] wide;
    wide = 64'(pred_page) << cfg_shift;
    expect_frame(pred_buf ? OP_COMMIT_ONE : OP_COMMIT_ZERO, wide[AddrBits-1:0], 1'b1);
    pred_buf  = ~pred_buf;
    pred_off  = '0;
    pred_page = pred_page + 1'b1;
  endfunction

  // spi bytes caused by one accepted log transaction
  function automatic void predict_spi_bytes(in_item_t it);
    int unsigned before_n;
    out_item_t   tail;
    before_n = spi_expect_q.size();
    case (it.mode)
      MODE_DATA: begin
        if (it.first_in_record) begin
          if ({1'b0, pred_off} + {1'b0, it.record_length} >= {1'b0, cfg_size})
            expect_page_commit();
          expect_frame(pred_buf ? OP_WR_BUF_ONE : OP_WR_BUF_ZERO,
                       AddrBits'(pred_off), 1'b0);
          pred_off = pred_off + it.record_length;
        end
        expect_byte(it.data_byte, it.last_in_record);
      end
      MODE_SYNC: begin
        if (pred_off != '0) expect_page_commit();
      end
      MODE_RESTART: begin
        pred_buf  = 1'b0;
        pred_off  = '0;
        pred_page = '0;
      end
      default: ;
    endcase
    if (spi_expect_q.size() > before_n) begin
      tail = spi_expect_q.pop_back();
      tail.last_result = 1'b1;
      spi_expect_q.push_back(tail);
    end
  endfunction

  // check spi bytes, then predict for the log transaction taken at this edge
  always @(posedge clk) begin : check_spi_bytes
    out_item_t want;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (spi_expect_q.size() == 0) begin
          $error("spi byte %02h with nothing expected", out_data_o.spi_byte);
          fail_count++;
        end else begin
          want = spi_expect_q.pop_front();
          if (out_data_o.spi_byte !== want.spi_byte) begin
            $error("spi_byte: expected %02h, got %02h", want.spi_byte, out_data_o.spi_byte);
            fail_count++;
          end
          if (out_data_o.end_of_frame !== want.end_of_frame) begin
            $error("end_of_frame: expected %0b, got %0b", want.end_of_frame,
                   out_data_o.end_of_frame);
            fail_count++;
          end
          if (out_data_o.last_result !== want.last_result) begin
            $error("last_result: expected %0b, got %0b", want.last_result,
                   out_data_o.last_result);
            fail_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) predict_spi_bytes(in_data_i);
      in_taken <= in_valid_i && !in_stall_o;
    end
  end

  // log byte driver, payload held while stalled
  always @(negedge clk) begin : drive_log_bytes
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (in_gap_left != 0) begin
        in_valid_i  <= 1'b0;
        in_gap_left <= in_gap_left - 1;
      end else if (log_byte_q.size() != 0) begin
        in_data_i   <= log_byte_q.pop_front();
        in_valid_i  <= 1'b1;
        in_gap_left <= random_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // spi side stall pattern
  always @(negedge clk) begin : drive_spi_stall
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else begin
      out_stall_i <= hold_off;
      stall_left  <= random_gap();
    end
  end

  // one long receiver hold-off so the block backs up into its input
  initial begin : spi_hold_off
    wait (hold_go);
    @(negedge clk);
    hold_off <= 1'b1;
    repeat (300) @(negedge clk);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    #(20_000_000);
    $display("dataflash_pingpong_log_writer_top test failed");
    $finish;
  end

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [OffsetBits-1:0] value);
    @(negedge clk);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    if (idx == CFG_BUFFER_SIZE) cfg_size = value;
    else if (idx == CFG_BYTE_ADDR_BITS) cfg_shift = value[ShiftBits-1:0];
    @(negedge clk);
    cfg_valid_i <= 1'b0;
  endtask

  // shift value with junk in the unused upper bits of the write data
  task automatic set_geometry(logic [OffsetBits-1:0] size, logic [ShiftBits-1:0] shift);
    write_reg(CFG_BUFFER_SIZE, size);
    write_reg(CFG_BYTE_ADDR_BITS, {7'($urandom), shift});
  endtask

  // wait until every transaction is sent and every spi byte has come back
  task automatic wait_for_idle();
    int unsigned waited;
    waited = 0;
    while ((log_byte_q.size() != 0 || in_valid_i || spi_expect_q.size() != 0)
           && waited < 200000) begin
      @(negedge clk);
      waited++;
    end
    if (spi_expect_q.size() != 0 || log_byte_q.size() != 0) begin
      $error("block did not drain: %0d log bytes unsent, %0d spi bytes missing",
             log_byte_q.size(), spi_expect_q.size());
      fail_count++;
      spi_expect_q.delete();
    end
    repeat (16) @(negedge clk);
  endtask

  // mostly well-formed records with random content, the rest syncs and noise
  task automatic queue_random_records(int unsigned count);
    int unsigned queued, lim, nbytes, r, k;
    logic [OffsetBits-1:0] len;
    queued = 0;
    while (queued < count) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        lim    = (cfg_size > 11'd32) ? cfg_size / 4 : 8;
        len    = ($urandom_range(0, 9) < 7) ? OffsetBits'($urandom_range(1, lim))
                                            : OffsetBits'($urandom);
        nbytes = $urandom_range(1, 4);
        log_byte_q.push_back(make_item(MODE_DATA, 8'($urandom), len, 1'b1, nbytes == 1));
        for (k = 1; k < nbytes; k++)
          log_byte_q.push_back(make_item(MODE_DATA, 8'($urandom), OffsetBits'($urandom),
                                         1'b0, k == nbytes - 1));
        queued += nbytes;
      end else if (r < 88) begin
        log_byte_q.push_back(make_item(MODE_SYNC, 8'($urandom), OffsetBits'($urandom),
                                       1'($urandom), 1'($urandom)));
        queued++;
      end else if (r < 91) begin
        log_byte_q.push_back(make_item(MODE_RESTART, 8'($urandom), OffsetBits'($urandom),
                                       1'($urandom), 1'($urandom)));
        queued++;
      end else if (r < 95) begin
        log_byte_q.push_back(make_item(MODE_IGNORE, 8'($urandom), OffsetBits'($urandom),
                                       1'($urandom), 1'($urandom)));
        queued++;
      end else begin
        // continuation byte outside any record
        log_byte_q.push_back(make_item(MODE_DATA, 8'($urandom), OffsetBits'($urandom),
                                       1'b0, 1'($urandom)));
        queued++;
      end
    end
  endtask

  initial begin : stimulus
    pred_buf  = 1'b0;
    pred_off  = '0;
    pred_page = '0;
    cfg_size  = BufferSizeReset;
    cfg_shift = AddrBitsReset;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    // directed records at the reset geometry
    log_byte_q.push_back(make_item(MODE_DATA, 8'h00, 11'd1, 1'b1, 1'b1));
    log_byte_q.push_back(make_item(MODE_DATA, 8'hFF, 11'd3, 1'b1, 1'b0));
    log_byte_q.push_back(make_item(MODE_DATA, 8'hA5, 11'h7FF, 1'b0, 1'b0));
    log_byte_q.push_back(make_item(MODE_DATA, 8'h5A, 11'd0, 1'b0, 1'b1));
    log_byte_q.push_back(make_item(MODE_DATA, 8'hC3, 11'd0, 1'b0, 1'b0));
    log_byte_q.push_back(make_item(MODE_SYNC, 8'hFF, 11'h7FF, 1'b1, 1'b1));
    log_byte_q.push_back(make_item(MODE_SYNC, 8'h00, 11'd0, 1'b0, 1'b0));
    log_byte_q.push_back(make_item(MODE_IGNORE, 8'hFF, 11'h7FF, 1'b1, 1'b1));
    log_byte_q.push_back(make_item(MODE_DATA, 8'h81, 11'd520, 1'b1, 1'b1));
    // offset plus length lands exactly on the buffer size
    log_byte_q.push_back(make_item(MODE_DATA, 8'h7E, 11'd8, 1'b1, 1'b1));
    // one short of the buffer size, then exactly on it
    log_byte_q.push_back(make_item(MODE_DATA, 8'h01, 11'd519, 1'b1, 1'b1));
    log_byte_q.push_back(make_item(MODE_DATA, 8'h02, 11'd1, 1'b1, 1'b1));
    // oversize records, the second one with a full offset
    log_byte_q.push_back(make_item(MODE_DATA, 8'hFF, 11'h7FF, 1'b1, 1'b0));
    log_byte_q.push_back(make_item(MODE_DATA, 8'h3C, 11'h7FF, 1'b1, 1'b1));
    log_byte_q.push_back(make_item(MODE_SYNC, 8'h00, 11'd0, 1'b0, 1'b0));
    log_byte_q.push_back(make_item(MODE_RESTART, 8'hFF, 11'h7FF, 1'b1, 1'b1));
    log_byte_q.push_back(make_item(MODE_DATA, 8'h96, 11'd5, 1'b1, 1'b1));
    wait_for_idle();

    // smallest usual buffer, short byte address
    set_geometry(11'd264, 4'd9);
    queue_random_records(70);
    wait_for_idle();

    // largest usual buffer with the receiver held off for a while
    set_geometry(11'd1056, 4'd11);
    hold_go = 1'b1;
    queue_random_records(70);
    wait_for_idle();

    // zero buffer size commits on every record start, widest shift
    set_geometry(11'd0, 4'd15);
    log_byte_q.push_back(make_item(MODE_SYNC, 8'h00, 11'd0, 1'b0, 1'b0));
    log_byte_q.push_back(make_item(MODE_DATA, 8'h11, 11'd1, 1'b1, 1'b1));
    queue_random_records(40);
    wait_for_idle();

    // full 11-bit buffer size, no shift
    set_geometry(11'h7FF, 4'd0);
    queue_random_records(50);
    wait_for_idle();

    // random geometry inside the usual range
    set_geometry(OffsetBits'($urandom_range(264, 1056)), ShiftBits'($urandom_range(9, 11)));
    queue_random_records(60);
    wait_for_idle();

    if (fail_count == 0)
      $display("dataflash_pingpong_log_writer_top test passed");
    else
      $display("dataflash_pingpong_log_writer_top test failed");
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/dpl_pkg.sv
src/dpl_plan.sv
src/dpl_emit.sv
src/dataflash_pingpong_log_writer_top.sv
verif/dataflash_pingpong_log_writer_top_tb.sv
